[rtl/smfp_pkg.sv]
// Shared types and constants for the Styx message field parser.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps
`default_nettype none

package smfp_pkg;

  localparam int MAX_FIELDS = 6;
  localparam int KIND_W     = 5;
  localparam int LEN_W      = 8;
  localparam int POS_W      = 8;
  localparam int SUM_W      = 9;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_TAG     = 5'd0;
  localparam kind_t KIND_OLDTAG  = 5'd1;
  localparam kind_t KIND_FID     = 5'd2;
  localparam kind_t KIND_NEWFID  = 5'd3;
  localparam kind_t KIND_MODE    = 5'd4;
  localparam kind_t KIND_PERM    = 5'd5;
  localparam kind_t KIND_OFFSET  = 5'd6;
  localparam kind_t KIND_COUNT   = 5'd7;
  localparam kind_t KIND_QPATH   = 5'd8;
  localparam kind_t KIND_QVERS   = 5'd9;
  localparam kind_t KIND_NAME    = 5'd10;
  localparam kind_t KIND_USER    = 5'd11;
  localparam kind_t KIND_ANAME   = 5'd12;
  localparam kind_t KIND_STAT    = 5'd13;
  localparam kind_t KIND_ETEXT   = 5'd14;
  localparam kind_t KIND_DATA    = 5'd15;
  localparam kind_t KIND_END     = 5'd16;
  localparam kind_t KIND_BAD     = 5'd17;
  localparam kind_t KIND_PAD     = 5'd31;

  // Per-type field layout; unused slots have zero length.
  typedef struct packed {
    logic [MAX_FIELDS-1:0][KIND_W-1:0] kind;
    logic [MAX_FIELDS-1:0][LEN_W-1:0]  len;
  } layout_t;

  // Where the current header byte falls within the message layout.
  typedef struct packed {
    logic             bad;
    logic             found;
    kind_t            kind;
    logic [LEN_W-1:0] fo;
    logic [LEN_W-1:0] len;
    logic             last_byte;
  } field_info_t;

  typedef struct packed {
    logic [7:0]  msg_type;
    kind_t       field_kind;
    logic [31:0] field_value;
    logic [15:0] byte_index;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

[rtl/smfp_field_map.sv]
// Field locator: maps a message type and header byte offset to its field.
// Depends on smfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smfp_field_map #(
  parameter int NAME_BYTES       = 28,
  parameter int ERROR_TEXT_BYTES = 64,
  parameter int STAT_BYTES       = 116
) (
  input  wire logic [7:0]                  msg_type_i,
  input  wire logic [smfp_pkg::POS_W-1:0]  offset_i,
  output smfp_pkg::field_info_t            info_o
);
  import smfp_pkg::*;

  localparam logic [7:0] T_NOP     = 8'd0;
  localparam logic [7:0] R_NOP     = 8'd1;
  localparam logic [7:0] R_ERROR   = 8'd3;
  localparam logic [7:0] T_FLUSH   = 8'd4;
  localparam logic [7:0] R_FLUSH   = 8'd5;
  localparam logic [7:0] T_CLONE   = 8'd6;
  localparam logic [7:0] R_CLONE   = 8'd7;
  localparam logic [7:0] T_WALK    = 8'd8;
  localparam logic [7:0] R_WALK    = 8'd9;
  localparam logic [7:0] T_OPEN    = 8'd10;
  localparam logic [7:0] R_OPEN    = 8'd11;
  localparam logic [7:0] T_CREATE  = 8'd12;
  localparam logic [7:0] R_CREATE  = 8'd13;
  localparam logic [7:0] T_READ    = 8'd14;
  localparam logic [7:0] R_READ    = 8'd15;
  localparam logic [7:0] T_WRITE   = 8'd16;
  localparam logic [7:0] R_WRITE   = 8'd17;
  localparam logic [7:0] T_CLUNK   = 8'd18;
  localparam logic [7:0] R_CLUNK   = 8'd19;
  localparam logic [7:0] T_REMOVE  = 8'd20;
  localparam logic [7:0] R_REMOVE  = 8'd21;
  localparam logic [7:0] T_STAT    = 8'd22;
  localparam logic [7:0] R_STAT    = 8'd23;
  localparam logic [7:0] T_WSTAT   = 8'd24;
  localparam logic [7:0] R_WSTAT   = 8'd25;
  localparam logic [7:0] T_ATTACH  = 8'd28;
  localparam logic [7:0] R_ATTACH  = 8'd29;

  localparam logic [LEN_W-1:0] NAME_LEN = LEN_W'(NAME_BYTES);
  localparam logic [LEN_W-1:0] ETXT_LEN = LEN_W'(ERROR_TEXT_BYTES);
  localparam logic [LEN_W-1:0] STAT_LEN = LEN_W'(STAT_BYTES);

  function automatic layout_t get_layout(input logic [7:0] t);
    layout_t l;
    l = '0;
    l.kind[0] = KIND_TAG;
    l.len[0]  = 8'd2;
    case (t)
      T_NOP, R_NOP, R_FLUSH: begin
      end
      R_ERROR: begin
        l.kind[1] = KIND_ETEXT; l.len[1] = ETXT_LEN;
      end
      T_FLUSH: begin
        l.kind[1] = KIND_OLDTAG; l.len[1] = 8'd2;
      end
      T_CLONE: begin
        l.kind[1] = KIND_FID;    l.len[1] = 8'd2;
        l.kind[2] = KIND_NEWFID; l.len[2] = 8'd2;
      end
      R_CLONE, T_CLUNK, R_CLUNK, T_REMOVE, R_REMOVE, T_STAT, R_WSTAT: begin
        l.kind[1] = KIND_FID; l.len[1] = 8'd2;
      end
      T_WALK: begin
        l.kind[1] = KIND_FID;  l.len[1] = 8'd2;
        l.kind[2] = KIND_NAME; l.len[2] = NAME_LEN;
      end
      R_WALK, R_OPEN, R_CREATE, R_ATTACH: begin
        l.kind[1] = KIND_FID;   l.len[1] = 8'd2;
        l.kind[2] = KIND_QPATH; l.len[2] = 8'd4;
        l.kind[3] = KIND_QVERS; l.len[3] = 8'd4;
      end
      T_OPEN: begin
        l.kind[1] = KIND_FID;  l.len[1] = 8'd2;
        l.kind[2] = KIND_MODE; l.len[2] = 8'd1;
      end
      T_CREATE: begin
        l.kind[1] = KIND_FID;  l.len[1] = 8'd2;
        l.kind[2] = KIND_NAME; l.len[2] = NAME_LEN;
        l.kind[3] = KIND_PERM; l.len[3] = 8'd4;
        l.kind[4] = KIND_MODE; l.len[4] = 8'd1;
      end
      T_READ: begin
        l.kind[1] = KIND_FID;    l.len[1] = 8'd2;
        l.kind[2] = KIND_OFFSET; l.len[2] = 8'd8;
        l.kind[3] = KIND_COUNT;  l.len[3] = 8'd2;
      end
      R_READ: begin
        l.kind[1] = KIND_FID;   l.len[1] = 8'd2;
        l.kind[2] = KIND_COUNT; l.len[2] = 8'd2;
        l.kind[3] = KIND_PAD;   l.len[3] = 8'd1;
      end
      T_WRITE: begin
        l.kind[1] = KIND_FID;    l.len[1] = 8'd2;
        l.kind[2] = KIND_OFFSET; l.len[2] = 8'd8;
        l.kind[3] = KIND_COUNT;  l.len[3] = 8'd2;
        l.kind[4] = KIND_PAD;    l.len[4] = 8'd1;
      end
      R_WRITE: begin
        l.kind[1] = KIND_FID;   l.len[1] = 8'd2;
        l.kind[2] = KIND_COUNT; l.len[2] = 8'd2;
      end
      R_STAT, T_WSTAT: begin
        l.kind[1] = KIND_FID;  l.len[1] = 8'd2;
        l.kind[2] = KIND_STAT; l.len[2] = STAT_LEN;
      end
      T_ATTACH: begin
        l.kind[1] = KIND_FID;   l.len[1] = 8'd2;
        l.kind[2] = KIND_USER;  l.len[2] = NAME_LEN;
        l.kind[3] = KIND_ANAME; l.len[3] = NAME_LEN;
      end
      default: begin
        l = '0;
      end
    endcase
    return l;
  endfunction

  layout_t          lay;
  logic [SUM_W-1:0] start;
  logic [SUM_W-1:0] off_ext;

  always_comb begin
    lay     = get_layout(msg_type_i);
    off_ext = {1'b0, offset_i};
    start   = '0;
    info_o  = '0;
    for (int i = 0; i < MAX_FIELDS; i++) begin
      if (!info_o.found && (off_ext < start + {1'b0, lay.len[i]})) begin
        info_o.found = 1'b1;
        info_o.kind  = lay.kind[i];
        info_o.len   = lay.len[i];
        info_o.fo    = LEN_W'(off_ext - start);
      end
      start = start + {1'b0, lay.len[i]};
    end
    info_o.bad       = (lay.len[0] == '0);
    info_o.last_byte = (off_ext + SUM_W'(1) == start);
  end

endmodule

`default_nettype wire

[rtl/smfp_out_stage.sv]
// Two-entry output register with skid slot for the parser results.
// Depends on smfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smfp_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_i,
  input  wire smfp_pkg::result_t res_i,
  output logic                   full_o,
  output logic                   valid_o,
  input  wire logic              stall_i,
  output smfp_pkg::result_t      res_o
);
  import smfp_pkg::*;

  logic    out_v_r, out_v_nxt;
  logic    skid_v_r, skid_v_nxt;
  result_t out_r, out_nxt;
  result_t skid_r, skid_nxt;
  logic    pop;

  assign pop     = out_v_r && !stall_i;
  assign full_o  = skid_v_r;
  assign valid_o = out_v_r;
  assign res_o   = out_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_nxt    = out_r;
    skid_nxt   = skid_r;
    if (!out_v_r) begin
      if (push_i) begin
        out_nxt   = res_i;
        out_v_nxt = 1'b1;
      end
    end else if (pop) begin
      if (skid_v_r) begin
        out_nxt    = skid_r;
        skid_v_nxt = 1'b0;
      end else if (push_i) begin
        out_nxt = res_i;
      end else begin
        out_v_nxt = 1'b0;
      end
    end else if (push_i) begin
      skid_nxt   = res_i;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

endmodule

`default_nettype wire

[rtl/styx_message_field_parser_core.sv]
// Styx message field parser: one stream byte in, at most one field result out.
// Results are registered: each one goes into the output register, or into the skid slot while that is held.
// Throughput: one byte per cycle while in_stall is low; the per-byte state update and the
// two-entry output stage keep input flowing while one result waits.
// Reset (synchronous, rst_n low): parser waits for a type byte, output empty.
// Depends on smfp_pkg, smfp_field_map and smfp_out_stage.
`timescale 1ns / 1ps
`default_nettype none

module styx_message_field_parser_core #(
  parameter int NAME_BYTES       = 28,
  parameter int ERROR_TEXT_BYTES = 64,
  parameter int STAT_BYTES       = 116
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_stream_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_msg_type,
  output logic [4:0]       out_field_kind,
  output logic [31:0]      out_field_value,
  output logic [15:0]      out_byte_index,
  output logic             out_last
);
  import smfp_pkg::*;

  // Parser state. Outside the payload, hdr_pos_r of zero means the next byte is a type byte.
  logic [POS_W-1:0] hdr_pos_r,   hdr_pos_nxt;
  logic [7:0]       cur_type_r,  cur_type_nxt;
  logic [31:0]      acc_r,       acc_nxt;
  logic [15:0]      pay_cnt_r,   pay_cnt_nxt;
  logic [15:0]      pay_pos_r,   pay_pos_nxt;
  logic             in_pay_r,    in_pay_nxt;

  logic             accept;
  logic             has_res;
  result_t          res;
  result_t          res_q;
  field_info_t      info;
  logic [7:0]       map_type;
  logic [POS_W-1:0] map_off;
  logic [31:0]      acc_merged;
  logic [15:0]      pay_pos_inc;

  assign accept = in_valid && !in_stall;

  // The type byte itself is looked up so a bad type is flagged at once.
  assign map_type = (hdr_pos_r == '0) ? in_stream_byte : cur_type_r;
  assign map_off  = hdr_pos_r - POS_W'(1);

  smfp_field_map #(
    .NAME_BYTES       (NAME_BYTES),
    .ERROR_TEXT_BYTES (ERROR_TEXT_BYTES),
    .STAT_BYTES       (STAT_BYTES)
  ) u_map (
    .msg_type_i (map_type),
    .offset_i   (map_off),
    .info_o     (info)
  );

  // Little-endian merge; bytes past the fourth (high half of the offset) drop.
  always_comb begin
    acc_merged = acc_r;
    if (info.fo < LEN_W'(4)) begin
      acc_merged = acc_r | (32'(in_stream_byte) << {info.fo[1:0], 3'b000});
    end
  end

  assign pay_pos_inc = pay_pos_r + 16'd1;

  always_comb begin
    hdr_pos_nxt  = hdr_pos_r;
    cur_type_nxt = cur_type_r;
    acc_nxt      = acc_r;
    pay_cnt_nxt  = pay_cnt_r;
    pay_pos_nxt  = pay_pos_r;
    in_pay_nxt   = in_pay_r;
    has_res      = 1'b0;
    res.msg_type    = cur_type_r;
    res.field_kind  = KIND_DATA;
    res.field_value = 32'(in_stream_byte);
    res.byte_index  = '0;
    res.last        = 1'b0;

    if (accept) begin
      if (in_pay_r) begin
        // Pass payload bytes through; close the message on the last one.
        has_res        = 1'b1;
        res.byte_index = pay_pos_r;
        pay_pos_nxt    = pay_pos_inc;
        if (pay_pos_inc == pay_cnt_r) begin
          res.last    = 1'b1;
          in_pay_nxt  = 1'b0;
          hdr_pos_nxt = '0;
        end
      end else if (hdr_pos_r == '0) begin
        cur_type_nxt = in_stream_byte;
        if (info.bad) begin
          // Reject the type; the next byte starts a new message.
          has_res         = 1'b1;
          res.msg_type    = in_stream_byte;
          res.field_kind  = KIND_BAD;
          res.field_value = '0;
          res.last        = 1'b1;
        end else begin
          acc_nxt     = '0;
          hdr_pos_nxt = POS_W'(1);
        end
      end else if (info.bad || !info.found) begin
        hdr_pos_nxt = '0;
      end else if (info.kind == KIND_PAD) begin
        // Skip the pad byte; an empty payload ends the message here.
        hdr_pos_nxt = '0;
        if (pay_cnt_r == '0) begin
          has_res         = 1'b1;
          res.field_kind  = KIND_END;
          res.field_value = '0;
          res.last        = 1'b1;
        end else begin
          in_pay_nxt  = 1'b1;
          pay_pos_nxt = '0;
        end
      end else begin
        if (info.kind >= KIND_NAME) begin
          // Fixed-length string byte.
          has_res        = 1'b1;
          res.field_kind = info.kind;
          res.byte_index = 16'(info.fo);
          res.last       = info.last_byte;
        end else if (info.fo + LEN_W'(1) == info.len) begin
          // Scalar complete: emit it and clear the accumulator.
          has_res         = 1'b1;
          res.field_kind  = info.kind;
          res.field_value = acc_merged;
          res.last        = info.last_byte;
          acc_nxt         = '0;
          if (info.kind == KIND_COUNT) begin
            pay_cnt_nxt = acc_merged[15:0];
          end
        end else begin
          acc_nxt = acc_merged;
        end
        hdr_pos_nxt = info.last_byte ? '0 : hdr_pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pos_r  <= '0;
      cur_type_r <= '0;
      acc_r      <= '0;
      pay_cnt_r  <= '0;
      pay_pos_r  <= '0;
      in_pay_r   <= 1'b0;
    end else begin
      hdr_pos_r  <= hdr_pos_nxt;
      cur_type_r <= cur_type_nxt;
      acc_r      <= acc_nxt;
      pay_cnt_r  <= pay_cnt_nxt;
      pay_pos_r  <= pay_pos_nxt;
      in_pay_r   <= in_pay_nxt;
    end
  end

  // Hold results here; stall input only when the skid slot is occupied.
  smfp_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (has_res),
    .res_i   (res),
    .full_o  (in_stall),
    .valid_o (out_valid),
    .stall_i (out_stall),
    .res_o   (res_q)
  );

  assign out_msg_type    = res_q.msg_type;
  assign out_field_kind  = res_q.field_kind;
  assign out_field_value = res_q.field_value;
  assign out_byte_index  = res_q.byte_index;
  assign out_last        = res_q.last;

endmodule

`default_nettype wire
